// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check under reset disable
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/bfha_pkg.sv =====
// Types and codes for the best-fit heap allocator.
// No dependencies.
package bfha_pkg;
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_NOFIT    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] request_size;
    logic [31:0] user_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } rsp_t;
endpackage

// ===== rtl/core/best_fit_heap_allocator_core.sv =====
// Top level of the best-fit heap allocator: sequencer and block table.
// Depends on bfha_pkg and assert_macros.svh.
//
// channel  dir  handshake           payload
// request  in   start & !busy       bfha_pkg::req_t
// result   out  done strobe         bfha_pkg::rsp_t
// config   in   cfg_valid&cfg_ready cfg_index, cfg_data
//
// Allocate and free requests walk the table through a single memory read
// port, a free stopping at the matching entry, then shift entries on a split
// or merge; init, zero-size allocate and the unused kind 3 go straight to done.
// Reset clears state, block count and heap registers; the table holds no reset value.
// The result strobe lasts one cycle and cannot be stalled.
`include "assert_macros.svh"
module best_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bfha_pkg::req_t   req,
  output logic             done,
  output bfha_pkg::rsp_t   rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCANW, S_ASPLIT, S_OPEN, S_OPENW, S_AFIN,
    S_FNEXT, S_FNEXTW, S_FPREV, S_FPREVW, S_DROP, S_DROPW, S_DONE
  } state_t;

  // table memory: start, size, taken in one word
  logic [64:0] mem [MAX_BLOCKS];
  logic [64:0] rd;
  logic [IW-1:0] ra;
  logic          we;
  logic [IW-1:0] wa;
  logic [64:0]   wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

  state_t state;
  logic [CW-1:0] count, idx, pos, best;
  logic          found;
  logic [31:0]   bsize, bstart, req_sz, uaddr, rem;
  logic [31:0]   heap_base, heap_size;
  logic [1:0]    kind;
  logic          drop_then_prev;

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  wire [31:0] rd_start = rd[64:33];
  wire [31:0] rd_size  = rd[32:1];
  wire        rd_taken = rd[0];

  always_comb begin
    ra = idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    done <= !rst && (state == S_DONE);
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      heap_base <= '0;
      heap_size <= '0;
      we <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          we <= start && (req.kind == bfha_pkg::KIND_INIT) && (heap_size > HDR);
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == bfha_pkg::CFG_HEAP_BASE) heap_base <= cfg_data;
            else heap_size <= cfg_data;
          end
          if (start) begin
            kind <= req.kind; req_sz <= req.request_size; uaddr <= req.user_address;
            idx <= '0; found <= 1'b0;
            rsp.result_address <= '0;
            case (req.kind)
              bfha_pkg::KIND_ALLOC: begin
                if (req.request_size == 32'd0) begin
                  rsp.status <= bfha_pkg::ST_ZERO; state <= S_DONE;
                end else begin
                  rsp.status <= bfha_pkg::ST_OK; state <= S_SCANW;
                end
              end
              bfha_pkg::KIND_FREE: begin
                rsp.status <= bfha_pkg::ST_OK; state <= S_SCANW;
              end
              bfha_pkg::KIND_INIT: begin
                if (heap_size <= HDR) begin
                  count <= '0; rsp.status <= bfha_pkg::ST_ZERO;
                end else begin
                  wa <= '0;
                  wd <= {heap_base + HDR, heap_size - HDR, 1'b0};
                  count <= CW'(1);
                  rsp.status <= bfha_pkg::ST_OK;
                end
                state <= S_DONE;
              end
              default: begin
                rsp.status <= bfha_pkg::ST_OK; state <= S_DONE;
              end
            endcase
          end
        end
        S_SCANW: begin
          // address idx presented; data next cycle
          we <= 1'b0;
          if (idx >= count) begin
            if (kind == bfha_pkg::KIND_ALLOC) state <= found ? S_ASPLIT : S_DONE;
            else state <= S_DONE;
            if (!found) rsp.status <= (kind == bfha_pkg::KIND_ALLOC) ?
                                      bfha_pkg::ST_NOFIT : bfha_pkg::ST_NOTFOUND;
          end else state <= S_SCAN;
        end
        S_SCAN: begin
          we <= 1'b0;
          if (kind == bfha_pkg::KIND_ALLOC) begin
            if (!rd_taken && rd_size >= req_sz && (!found || rd_size < bsize)) begin
              found <= 1'b1; best <= idx; bsize <= rd_size; bstart <= rd_start;
            end
            idx <= idx + CW'(1);
            state <= S_SCANW;
          end else if (rd_start == uaddr) begin
            found <= 1'b1; pos <= idx; bsize <= rd_size; bstart <= rd_start;
            idx <= idx + CW'(1);
            state <= S_FNEXTW;
          end else begin
            idx <= idx + CW'(1);
            state <= S_SCANW;
          end
        end
        S_ASPLIT: begin
          rem <= bsize - req_sz;
          rsp.result_address <= bstart;
          we <= 1'b1; wa <= best[IW-1:0];
          if ((bsize - req_sz) > HDR && count < CMAX) begin
            wd <= {bstart, req_sz, 1'b1};
            idx <= count - CW'(1);
            state <= S_OPENW;
          end else begin
            wd <= {bstart, bsize, 1'b1};
            state <= S_DONE;
          end
        end
        S_OPENW: begin
          we <= 1'b0;
          if (idx <= best) state <= S_AFIN;
          else state <= S_OPEN;
        end
        S_OPEN: begin
          // move entry idx up by one
          we <= 1'b1; wa <= IW'(idx + CW'(1)); wd <= rd;
          idx <= idx - CW'(1);
          state <= S_OPENW;
        end
        S_AFIN: begin
          we <= 1'b1; wa <= IW'(best + CW'(1));
          wd <= {bstart + req_sz + HDR, rem - HDR, 1'b0};
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_FNEXTW: begin
          we <= 1'b0;
          state <= S_FNEXT;
        end
        S_FNEXT: begin
          // rd holds entry pos+1 (valid only if pos+1 < count)
          if (pos + CW'(1) < count && !rd_taken) begin
            bsize <= bsize + rd_size + HDR;
            drop_then_prev <= 1'b1;
            idx <= pos + CW'(2);
            state <= S_DROPW;
          end else begin
            idx <= pos - CW'(1);
            state <= S_FPREVW;
          end
          we <= 1'b1; wa <= pos[IW-1:0];
          wd <= {bstart, (pos + CW'(1) < count && !rd_taken) ?
                 bsize + rd_size + HDR : bsize, 1'b0};
        end
        S_DROPW: begin
          we <= 1'b0;
          if (idx >= count) begin
            count <= count - CW'(1);
            if (drop_then_prev) begin
              idx <= pos - CW'(1);
              state <= S_FPREVW;
            end else state <= S_DONE;
          end else state <= S_DROP;
        end
        S_DROP: begin
          we <= 1'b1; wa <= IW'(idx - CW'(1)); wd <= rd;
          idx <= idx + CW'(1);
          state <= S_DROPW;
        end
        S_FPREVW: begin
          we <= 1'b0;
          if (pos == '0) state <= S_DONE;
          else state <= S_FPREV;
        end
        S_FPREV: begin
          we <= !rd_taken;
          if (!rd_taken) begin
            wa <= IW'(pos - CW'(1));
            wd <= {rd_start, rd_size + bsize + HDR, 1'b0};
            drop_then_prev <= 1'b0;
            idx <= pos + CW'(1);
            state <= S_DROPW;
          end else state <= S_DONE;
        end
        S_DONE: begin
          we <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          we <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CMAX, "block count overflow")
  `ASSERT_NEXT(a_done_idle, clk, rst, state == S_DONE, done && state == S_IDLE,
               "done not strobed")
  `ASSERT_IMPL(a_cfg_idle, clk, rst, cfg_ready, !busy, "config accepted while busy")
endmodule

// ===== sim/tb_best_fit_heap_allocator_core.sv =====
// Self-checking testbench for best_fit_heap_allocator_core: directed and random
// allocate/free/init traffic against a behavioral best-fit heap table.
// Depends on bfha_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_best_fit_heap_allocator_core;

  localparam int MAXB = 64;
  localparam int HDR = 24;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bfha_pkg::req_t req = '0;
  logic done;
  bfha_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  best_fit_heap_allocator_core #(.MAX_BLOCKS(MAXB), .HEADER_BYTES(HDR)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shadow heap table
  logic [31:0] heap_base_q, heap_size_q;
  logic [31:0] blk_addr [MAXB];
  logic [31:0] blk_len [MAXB];
  logic blk_used [MAXB];
  int blk_num;
  bfha_pkg::rsp_t pending_rsp [$];
  int errors = 0;
  int cycles = 0;
  // addresses returned by allocations since the last init, used to build frees
  logic [31:0] live_addrs [$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    bfha_pkg::rsp_t exp_r;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result addr=%h status=%0d", rsp.result_address, rsp.status);
        errors++;
      end else begin
        exp_r = pending_rsp.pop_front();
        if (rsp.result_address !== exp_r.result_address) begin
          $error("result_address expected %h actual %h", exp_r.result_address,
                 rsp.result_address);
          errors++;
        end
        if (rsp.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, rsp.status);
          errors++;
        end
      end
    end
  end

  function automatic void remove_slot(int pos);
    for (int i = pos; i + 1 < blk_num; i++) begin
      blk_addr[i] = blk_addr[i+1];
      blk_len[i] = blk_len[i+1];
      blk_used[i] = blk_used[i+1];
    end
    blk_num--;
  endfunction

  function automatic bfha_pkg::rsp_t predict_heap(bfha_pkg::req_t r);
    bfha_pkg::rsp_t o;
    int best;
    int pos;
    logic [31:0] rem;
    o = '0;
    o.status = bfha_pkg::ST_OK;
    case (r.kind)
      bfha_pkg::KIND_INIT: begin
        if (heap_size_q <= HDR) begin
          blk_num = 0;
          o.status = bfha_pkg::ST_ZERO;
        end else begin
          blk_addr[0] = heap_base_q + HDR;
          blk_len[0] = heap_size_q - HDR;
          blk_used[0] = 1'b0;
          blk_num = 1;
        end
      end
      bfha_pkg::KIND_ALLOC: begin
        best = -1;
        if (r.request_size == 0) o.status = bfha_pkg::ST_ZERO;
        else begin
          for (int i = 0; i < blk_num; i++)
            if (!blk_used[i] && blk_len[i] >= r.request_size &&
                (best < 0 || blk_len[i] < blk_len[best])) best = i;
          if (best < 0) o.status = bfha_pkg::ST_NOFIT;
          else begin
            rem = blk_len[best] - r.request_size;
            blk_used[best] = 1'b1;
            if (rem > HDR && blk_num < MAXB) begin
              blk_len[best] = r.request_size;
              for (int i = blk_num; i > best + 1; i--) begin
                blk_addr[i] = blk_addr[i-1];
                blk_len[i] = blk_len[i-1];
                blk_used[i] = blk_used[i-1];
              end
              blk_num++;
              blk_addr[best+1] = blk_addr[best] + r.request_size + HDR;
              blk_len[best+1] = rem - HDR;
              blk_used[best+1] = 1'b0;
            end
            o.result_address = blk_addr[best];
          end
        end
      end
      bfha_pkg::KIND_FREE: begin
        pos = -1;
        for (int i = 0; i < blk_num; i++)
          if (pos < 0 && blk_addr[i] == r.user_address) pos = i;
        if (pos < 0) o.status = bfha_pkg::ST_NOTFOUND;
        else begin
          blk_used[pos] = 1'b0;
          if (pos + 1 < blk_num && !blk_used[pos+1]) begin
            blk_len[pos] = blk_len[pos] + blk_len[pos+1] + HDR;
            remove_slot(pos + 1);
          end
          if (pos > 0 && !blk_used[pos-1]) begin
            blk_len[pos-1] = blk_len[pos-1] + blk_len[pos] + HDR;
            remove_slot(pos);
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // start stays high across back-to-back beats; it drops only in a gap or a drain
  task automatic send_request(logic [1:0] kind, logic [31:0] size, logic [31:0] addr);
    bfha_pkg::req_t r;
    r.kind = kind;
    r.request_size = size;
    r.user_address = addr;
    // random gap before some beats
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(predict_heap(r));
    if (kind == bfha_pkg::KIND_ALLOC && pending_rsp[$].status == bfha_pkg::ST_OK)
      live_addrs.push_back(pending_rsp[$].result_address);
    if (kind == bfha_pkg::KIND_INIT) live_addrs.delete();
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2 * MAXB + 20) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == bfha_pkg::CFG_HEAP_BASE) heap_base_q = val;
    else heap_size_q = val;
  endtask

  task automatic set_heap(logic [31:0] base, logic [31:0] size);
    drain();
    write_cfg(bfha_pkg::CFG_HEAP_BASE, base);
    write_cfg(bfha_pkg::CFG_HEAP_SIZE, size);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed;
    // alloc/free on empty table
    send_request(bfha_pkg::KIND_ALLOC, 32'd16, 32'h0);
    send_request(bfha_pkg::KIND_FREE, 32'h0, 32'hFFFF_FFFF);
    set_heap(32'h0, HDR);
    send_request(bfha_pkg::KIND_INIT, 0, 0);
    set_heap(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_request(bfha_pkg::KIND_INIT, 0, 0);
    send_request(bfha_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 0);
    send_request(bfha_pkg::KIND_ALLOC, 0, 0);
    send_request(bfha_pkg::KIND_ALLOC, 32'h100, 0);
    set_heap(32'h1000, 32'd400);
    send_request(bfha_pkg::KIND_INIT, 0, 0);
    send_request(bfha_pkg::KIND_ALLOC, 32'd40, 0);
    send_request(bfha_pkg::KIND_ALLOC, 32'd40, 0);
    send_request(bfha_pkg::KIND_ALLOC, 32'd40, 0);
    send_request(bfha_pkg::KIND_FREE, 0, 32'h1000 + HDR);
    send_request(bfha_pkg::KIND_FREE, 0, 32'h1000 + HDR);
    send_request(bfha_pkg::KIND_FREE, 0, 32'h1000 + 3 * HDR + 80);
    send_request(bfha_pkg::KIND_ALLOC, 32'd30, 0);
    send_request(bfha_pkg::KIND_ALLOC, 32'd500, 0);
    send_request(bfha_pkg::KIND_FREE, 0, 32'h1234);
    send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(bfha_pkg::KIND_FREE, 0, 32'h1000 + 2 * HDR + 40);
  endtask

  task automatic test_random;
    int pick;
    logic [31:0] a;
    for (int n = 0; n < 1500; n++) begin
      if (n % 300 == 0) begin
        case ($urandom_range(0, 2))
          0: set_heap($urandom, $urandom_range(HDR + 1, 20000));
          1: set_heap($urandom, $urandom);
          default: set_heap(32'h0, $urandom_range(2000, 8000));
        endcase
        send_request(bfha_pkg::KIND_INIT, $urandom, $urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50)
        send_request(bfha_pkg::KIND_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom :
                     $urandom_range(0, 200), $urandom);
      else if (pick < 88 && live_addrs.size() != 0) begin
        a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        send_request(bfha_pkg::KIND_FREE, $urandom, a);
      end else if (pick < 95)
        send_request(bfha_pkg::KIND_FREE, $urandom, $urandom);
      else if (pick < 98)
        send_request(2'd3, $urandom, $urandom);
      else
        send_request(bfha_pkg::KIND_INIT, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
